// ===== hw/rtl/sta_pkg.sv =====
package sta_pkg;

    localparam int MAX_DIMS      = 6;
    localparam int SIZE_BITS     = 10;
    localparam int ORDER_BITS    = 3;
    localparam int RANK_BITS     = 3;
    localparam int OFS_BITS      = 60;
    localparam int SIZES_BITS    = MAX_DIMS * SIZE_BITS;
    localparam int ORDERS_BITS   = MAX_DIMS * ORDER_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 60;
    localparam int CNT_BITS      = $clog2(MAX_DIMS);
    localparam int PROD_BITS     = OFS_BITS + SIZE_BITS;
    localparam int HALF_DIMS     = (MAX_DIMS + 1) / 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RANK      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_SIZES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_ORDER = 2'd2;

    localparam logic [RANK_BITS-1:0]   RANK_RESET  = 3'd1;
    localparam logic [SIZES_BITS-1:0]  SIZES_RESET = {MAX_DIMS{10'd1}};
    localparam logic [ORDERS_BITS-1:0] ORDER_RESET = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    typedef logic [MAX_DIMS-1:0][SIZE_BITS-1:0] t_idx_vec;

    typedef struct packed {
        logic                               busy;
        logic [MAX_DIMS-1:0]                used;
        logic [MAX_DIMS-1:0][SIZE_BITS-1:0] size;
        logic [MAX_DIMS-1:0][OFS_BITS-1:0]  stride;
    } t_view_cfg;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_STRIDE,
        SEQ_PERM
    } t_seq_state;

endpackage

// ===== hw/rtl/sta_in_if.sv =====
interface sta_in_if;
    import sta_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] index_0;
    logic [SIZE_BITS-1:0] index_1;
    logic [SIZE_BITS-1:0] index_2;
    logic [SIZE_BITS-1:0] index_3;
    logic [SIZE_BITS-1:0] index_4;
    logic [SIZE_BITS-1:0] index_5;

    modport source (
        output valid, index_0, index_1, index_2, index_3, index_4, index_5,
        input  ready
    );
    modport sink (
        input  valid, index_0, index_1, index_2, index_3, index_4, index_5,
        output ready
    );
endinterface

// ===== hw/rtl/sta_out_if.sv =====
interface sta_out_if;
    import sta_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFS_BITS-1:0] flat_offset;
    logic                out_of_range;

    modport source (
        output valid, flat_offset, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, flat_offset, out_of_range,
        output ready
    );
endinterface

// ===== hw/rtl/sta_cfg.sv =====
module sta_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [sta_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output sta_pkg::t_view_cfg                 o_view
);
    import sta_pkg::*;

    logic [RANK_BITS-1:0]   r_rank;
    logic [SIZES_BITS-1:0]  r_sizes;
    logic [ORDERS_BITS-1:0] r_order;
    t_seq_state             r_state, n_state;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [OFS_BITS-1:0]    r_stride [MAX_DIMS];

    logic [MAX_DIMS-1:0][OFS_BITS-1:0]  r_pstride;
    logic [MAX_DIMS-1:0][SIZE_BITS-1:0] r_psize;
    logic [MAX_DIMS-1:0]                r_used;

    logic [RANK_BITS-1:0]  eff_rank;
    logic                  order_ok;
    logic                  cfg_hit;
    logic [CNT_BITS-1:0]   cnt_m1;
    logic [PROD_BITS-1:0]  step_prod;
    logic                  lane_used;
    logic [CNT_BITS-1:0]   src;

    always_comb begin
        if (r_rank == '0) begin
            eff_rank = RANK_BITS'(1);
        end else if (r_rank > RANK_BITS'(MAX_DIMS)) begin
            eff_rank = RANK_BITS'(MAX_DIMS);
        end else begin
            eff_rank = r_rank;
        end
    end

    // The order is usable only if its first rank entries are distinct axes below rank.
    always_comb begin
        logic [ORDER_BITS-1:0] a;
        order_ok = 1'b1;
        for (int k = 0; k < MAX_DIMS; k++) begin
            a = r_order[k*ORDER_BITS +: ORDER_BITS];
            if (RANK_BITS'(k) < eff_rank) begin
                if (RANK_BITS'(a) >= eff_rank) begin
                    order_ok = 1'b0;
                end
                for (int j = 0; j < k; j++) begin
                    if (r_order[j*ORDER_BITS +: ORDER_BITS] == a) begin
                        order_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign cfg_hit   = i_cfg_we && (i_cfg_idx inside {CFG_RANK, CFG_DIM_SIZES, CFG_DIM_ORDER});
    assign cnt_m1    = r_cnt - CNT_BITS'(1);
    assign step_prod = PROD_BITS'(r_stride[r_cnt])
                     * PROD_BITS'(r_sizes[r_cnt*SIZE_BITS +: SIZE_BITS]);
    assign lane_used = RANK_BITS'(r_cnt) < eff_rank;
    assign src       = (lane_used && order_ok)
                     ? CNT_BITS'(r_order[r_cnt*ORDER_BITS +: ORDER_BITS]) : r_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            SEQ_IDLE: begin
                n_cnt = '0;
            end
            SEQ_INIT: begin
                if (eff_rank == RANK_BITS'(1)) begin
                    n_state = SEQ_PERM;
                    n_cnt   = '0;
                end else begin
                    n_state = SEQ_STRIDE;
                    n_cnt   = CNT_BITS'(eff_rank - RANK_BITS'(1));
                end
            end
            SEQ_STRIDE: begin
                if (r_cnt == CNT_BITS'(1)) begin
                    n_state = SEQ_PERM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = cnt_m1;
                end
            end
            SEQ_PERM: begin
                if (r_cnt == CNT_BITS'(MAX_DIMS - 1)) begin
                    n_state = SEQ_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_BITS'(1);
                end
            end
            default: begin
                n_state = SEQ_IDLE;
                n_cnt   = '0;
            end
        endcase
        if (cfg_hit) begin
            n_state = SEQ_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_INIT;
            r_cnt   <= '0;
            r_rank  <= RANK_RESET;
            r_sizes <= SIZES_RESET;
            r_order <= ORDER_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RANK:      r_rank  <= i_cfg_data[RANK_BITS-1:0];
                    CFG_DIM_SIZES: r_sizes <= i_cfg_data[SIZES_BITS-1:0];
                    CFG_DIM_ORDER: r_order <= i_cfg_data[ORDERS_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SEQ_INIT: begin
                for (int i = 0; i < MAX_DIMS; i++) begin
                    r_stride[i] <= (RANK_BITS'(i) == eff_rank - RANK_BITS'(1))
                                 ? OFS_BITS'(1) : '0;
                end
            end
            SEQ_STRIDE: begin
                r_stride[cnt_m1] <= step_prod[OFS_BITS-1:0];
            end
            SEQ_PERM: begin
                r_pstride[r_cnt] <= lane_used ? r_stride[src] : '0;
                r_psize[r_cnt]   <= r_sizes[src*SIZE_BITS +: SIZE_BITS];
                r_used[r_cnt]    <= lane_used;
            end
            default: begin
            end
        endcase
    end

    assign o_view.busy   = (r_state != SEQ_IDLE);
    assign o_view.used   = r_used;
    assign o_view.size   = r_psize;
    assign o_view.stride = r_pstride;

endmodule

// ===== hw/rtl/sta_pipe.sv =====
module sta_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    output logic                          o_ready,
    input  sta_pkg::t_idx_vec             i_idx,
    input  sta_pkg::t_view_cfg            i_view,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sta_pkg::OFS_BITS-1:0]  o_offset,
    output logic                          o_oor
);
    import sta_pkg::*;

    logic                              r_v1, r_v2, r_v3, r_v4;
    t_idx_vec                          r_idx1;
    logic [MAX_DIMS-1:0][OFS_BITS-1:0] r_prod2, n_prod2;
    logic [MAX_DIMS-1:0]               r_flag2, n_flag2;
    logic [HALF_DIMS-1:0][OFS_BITS-1:0] r_sum3, n_sum3;
    logic                              r_oor3;
    logic [OFS_BITS-1:0]               r_off4, n_off4;
    logic                              r_oor4;
    logic                              en1, en2, en3, en4;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_comb begin
        logic [PROD_BITS-1:0] p;
        for (int k = 0; k < MAX_DIMS; k++) begin
            p          = PROD_BITS'(i_view.stride[k]) * PROD_BITS'(r_idx1[k]);
            n_prod2[k] = p[OFS_BITS-1:0];
            n_flag2[k] = i_view.used[k] && (r_idx1[k] >= i_view.size[k]);
        end
    end

    always_comb begin
        for (int j = 0; j < HALF_DIMS; j++) begin
            if (2*j + 1 < MAX_DIMS) begin
                n_sum3[j] = r_prod2[2*j] + r_prod2[2*j+1];
            end else begin
                n_sum3[j] = r_prod2[2*j];
            end
        end
    end

    always_comb begin
        n_off4 = '0;
        for (int j = 0; j < HALF_DIMS; j++) begin
            n_off4 = n_off4 + r_sum3[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_take;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_idx1 <= i_idx;
        end
        if (en2) begin
            r_prod2 <= n_prod2;
            r_flag2 <= n_flag2;
        end
        if (en3) begin
            r_sum3 <= n_sum3;
            r_oor3 <= |r_flag2;
        end
        if (en4) begin
            r_off4 <= n_off4;
            r_oor4 <= r_oor3;
        end
    end

    assign o_valid  = r_v4;
    assign o_offset = r_off4;
    assign o_oor    = r_oor4;

endmodule

// ===== hw/rtl/strided_tensor_address.sv =====
// Strided tensor address generator. Each transfer on i_in carries one coordinate
// per view axis, and each transfer on o_out returns the flat row-major element
// offset of that coordinate and a flag that is set when a used coordinate is at
// or above the size of its axis. Coordinates beyond the configured rank are ignored.
// The configuration port writes rank, the packed dimension sizes and the packed
// axis order. A write to one of these three registers starts a table rebuild:
// strides are formed one axis per cycle through a single multiplier, then the
// permuted view is stored one axis per cycle, and i_in.ready stays low until the
// rebuild has finished. Reset loads the default configuration and runs the same
// rebuild, so the block first accepts a transfer once that rebuild has finished.
// The datapath is a four stage pipeline: input register, one multiplier per axis,
// a pairwise add stage, and a final add into the output register. o_out.valid rises
// when an input transfer has passed through all four registers, and one transfer
// per cycle is sustained while o_out.ready is high and no rebuild runs. When the
// receiver stalls, the stages behind the output register keep filling until the
// pipeline is full; no transfer is lost or repeated.
module strided_tensor_address (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sta_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [sta_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    sta_in_if.sink                            i_in,
    sta_out_if.source                         o_out
);
    import sta_pkg::*;

    t_view_cfg view;
    t_idx_vec  idx;
    logic      pipe_ready;

    assign idx[0] = i_in.index_0;
    assign idx[1] = i_in.index_1;
    assign idx[2] = i_in.index_2;
    assign idx[3] = i_in.index_3;
    assign idx[4] = i_in.index_4;
    assign idx[5] = i_in.index_5;

    assign i_in.ready = pipe_ready && !view.busy;

    sta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_view     (view)
    );

    sta_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (i_in.valid && i_in.ready),
        .o_ready  (pipe_ready),
        .i_idx    (idx),
        .i_view   (view),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_offset (o_out.flat_offset),
        .o_oor    (o_out.out_of_range)
    );

endmodule

// ===== tb/sta_tb_pkg.sv =====
`timescale 1ns / 100ps
package sta_tb_pkg;
    import sta_pkg::*;

    class offset_scoreboard;
        logic [RANK_BITS-1:0]   rank_reg;
        logic [SIZES_BITS-1:0]  sizes_reg;
        logic [ORDERS_BITS-1:0] order_reg;
        logic [OFS_BITS-1:0]    strides [MAX_DIMS];
        logic [OFS_BITS-1:0]    expected_offsets [$];
        logic                   expected_flags [$];
        int                     mismatches;
        int                     accepted;
        int                     returned;
        int                     flagged;

        function new();
            rank_reg   = RANK_RESET;
            sizes_reg  = SIZES_RESET;
            order_reg  = ORDER_RESET;
            mismatches = 0;
            accepted   = 0;
            returned   = 0;
            flagged    = 0;
            rebuild_strides();
        endfunction

        function int used_rank();
            int r;
            r = int'(rank_reg);
            if (r == 0) begin
                r = 1;
            end
            if (r > MAX_DIMS) begin
                r = MAX_DIMS;
            end
            return r;
        endfunction

        function logic [SIZE_BITS-1:0] size_of(int k);
            return sizes_reg[k*SIZE_BITS +: SIZE_BITS];
        endfunction

        function int axis_of(int k);
            return int'(order_reg[k*ORDER_BITS +: ORDER_BITS]);
        endfunction

        function void rebuild_strides();
            int r;
            r = used_rank();
            for (int i = 0; i < MAX_DIMS; i++) begin
                strides[i] = '0;
            end
            strides[r-1] = OFS_BITS'(1);
            for (int i = r - 1; i > 0; i--) begin
                strides[i-1] = strides[i] * OFS_BITS'(size_of(i));
            end
        endfunction

        function bit order_is_permutation(int r);
            bit seen [8];
            int a;
            for (int i = 0; i < 8; i++) begin
                seen[i] = 1'b0;
            end
            for (int k = 0; k < r; k++) begin
                a = axis_of(k);
                if (a >= r || seen[a]) begin
                    return 1'b0;
                end
                seen[a] = 1'b1;
            end
            return 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_RANK: begin
                    rank_reg = data[RANK_BITS-1:0];
                    rebuild_strides();
                end
                CFG_DIM_SIZES: begin
                    sizes_reg = data[SIZES_BITS-1:0];
                    rebuild_strides();
                end
                CFG_DIM_ORDER: begin
                    order_reg = data[ORDERS_BITS-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_input(t_idx_vec coords);
            int                  r;
            int                  src;
            bit                  ok;
            logic [OFS_BITS-1:0] offset;
            logic                out_of_range;
            r            = used_rank();
            ok           = order_is_permutation(r);
            offset       = '0;
            out_of_range = 1'b0;
            for (int k = 0; k < r; k++) begin
                src = ok ? axis_of(k) : k;
                if (src >= MAX_DIMS) begin
                    src = k;
                end
                offset = offset + strides[src] * OFS_BITS'(coords[k]);
                if (coords[k] >= size_of(src)) begin
                    out_of_range = 1'b1;
                end
            end
            expected_offsets.push_back(offset);
            expected_flags.push_back(out_of_range);
            accepted++;
            if (out_of_range) begin
                flagged++;
            end
        endfunction

        function void check_result(logic [OFS_BITS-1:0] offset, logic out_of_range);
            logic [OFS_BITS-1:0] want_offset;
            logic                want_flag;
            if (expected_offsets.size() == 0) begin
                $error("unexpected result transfer: flat_offset %0h, out_of_range %0b",
                       offset, out_of_range);
                mismatches++;
                return;
            end
            want_offset = expected_offsets.pop_front();
            want_flag   = expected_flags.pop_front();
            returned++;
            if (offset !== want_offset) begin
                $error("flat_offset: expected %0h, actual %0h", want_offset, offset);
                mismatches++;
            end
            if (out_of_range !== want_flag) begin
                $error("out_of_range: expected %0b, actual %0b", want_flag, out_of_range);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_offsets.size();
        endfunction
    endclass

endpackage

// ===== tb/strided_tensor_address_tb.sv =====
`timescale 1ns / 100ps
module strided_tensor_address_tb;
    import sta_pkg::*;
    import sta_tb_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REBUILD_CYCLES = 16;
    localparam int RANDOM_PHASES  = 16;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    sta_in_if  in_if ();
    sta_out_if out_if ();

    strided_tensor_address dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    offset_scoreboard sb;
    int               cycles = 0;
    int               configs = 0;
    bit               calm_in = 1'b0;
    bit               calm_out = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            sb.note_input({in_if.index_5, in_if.index_4, in_if.index_3,
                           in_if.index_2, in_if.index_1, in_if.index_0});
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.flat_offset, out_if.out_of_range);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = calm_out ? 0 : int'($urandom_range(0, 12));
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            @(negedge i_clk);
        end
    end

    function automatic t_idx_vec coords(int c0, int c1, int c2, int c3, int c4, int c5);
        t_idx_vec v;
        v[0] = SIZE_BITS'(c0);
        v[1] = SIZE_BITS'(c1);
        v[2] = SIZE_BITS'(c2);
        v[3] = SIZE_BITS'(c3);
        v[4] = SIZE_BITS'(c4);
        v[5] = SIZE_BITS'(c5);
        return v;
    endfunction

    function automatic logic [SIZES_BITS-1:0] sizes(int s0, int s1, int s2, int s3, int s4,
                                                   int s5);
        return {SIZE_BITS'(s5), SIZE_BITS'(s4), SIZE_BITS'(s3),
                SIZE_BITS'(s2), SIZE_BITS'(s1), SIZE_BITS'(s0)};
    endfunction

    function automatic logic [ORDERS_BITS-1:0] orders(int a0, int a1, int a2, int a3, int a4,
                                                     int a5);
        return {ORDER_BITS'(a5), ORDER_BITS'(a4), ORDER_BITS'(a3),
                ORDER_BITS'(a2), ORDER_BITS'(a1), ORDER_BITS'(a0)};
    endfunction

    // Mostly in-range coordinates along used axes, so that offsets land inside the tensor.
    function automatic t_idx_vec random_coords();
        t_idx_vec v;
        int       r;
        int       src;
        int       lim;
        r = sb.used_rank();
        for (int k = 0; k < MAX_DIMS; k++) begin
            src = sb.axis_of(k);
            if (src >= MAX_DIMS) begin
                src = k;
            end
            lim = int'(sb.size_of(src));
            if (k < r && lim > 0 && $urandom_range(0, 99) < 85) begin
                v[k] = SIZE_BITS'($urandom_range(0, lim - 1));
            end else begin
                v[k] = SIZE_BITS'($urandom_range(0, 1023));
            end
        end
        return v;
    endfunction

    task automatic send_item(input t_idx_vec v);
        int gap;
        gap = calm_in ? 0 : int'($urandom_range(0, 12));
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.index_0 <= v[0];
        in_if.index_1 <= v[1];
        in_if.index_2 <= v[2];
        in_if.index_3 <= v[3];
        in_if.index_4 <= v[4];
        in_if.index_5 <= v[5];
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        repeat (REBUILD_CYCLES) @(negedge i_clk);
    endtask

    task automatic setup(input int r, input logic [SIZES_BITS-1:0] s,
                         input logic [ORDERS_BITS-1:0] o);
        wait_drained();
        write_reg(CFG_RANK, CFG_DATA_BITS'(r));
        write_reg(CFG_DIM_SIZES, s);
        write_reg(CFG_DIM_ORDER, CFG_DATA_BITS'(o));
        configs++;
    endtask

    task automatic random_setup();
        int                     r;
        int                     used;
        int                     roll;
        int                     j;
        int                     tmp;
        int                     perm [MAX_DIMS];
        logic [63:0]            noise;
        logic [SIZES_BITS-1:0]  sizes_w;
        logic [ORDERS_BITS-1:0] order_w;
        roll = $urandom_range(0, 9);
        r    = (roll == 0) ? 0 : (roll == 1) ? 7 : int'($urandom_range(1, MAX_DIMS));
        used = (r == 0) ? 1 : (r > MAX_DIMS) ? MAX_DIMS : r;
        for (int k = 0; k < MAX_DIMS; k++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                tmp = 0;
            end else if (roll <= 2) begin
                tmp = 1023;
            end else if (roll <= 11) begin
                tmp = $urandom_range(1, 8);
            end else begin
                tmp = $urandom_range(1, 1023);
            end
            sizes_w[k*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(tmp);
            perm[k] = (k < used) ? k : int'($urandom_range(0, 7));
        end
        for (int k = used - 1; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
            order_w[k*ORDER_BITS +: ORDER_BITS] = ORDER_BITS'(perm[k]);
        end
        if ($urandom_range(0, 4) == 0) begin
            order_w = ORDERS_BITS'($urandom);
        end
        wait_drained();
        noise = {$urandom, $urandom};
        write_reg(CFG_RANK, {noise[CFG_DATA_BITS-1:RANK_BITS], RANK_BITS'(r)});
        write_reg(CFG_DIM_SIZES, sizes_w);
        noise = {$urandom, $urandom};
        write_reg(CFG_DIM_ORDER, {noise[CFG_DATA_BITS-1:ORDERS_BITS], order_w});
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_SPARE, noise[CFG_DATA_BITS-1:0]);
        end
        configs++;
    endtask

    initial begin : stimulus
        int n;
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_if.valid   = 1'b0;
        in_if.index_0 = '0;
        in_if.index_1 = '0;
        in_if.index_2 = '0;
        in_if.index_3 = '0;
        in_if.index_4 = '0;
        in_if.index_5 = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The reset view is a single axis of size one.
        send_item(coords(0, 0, 0, 0, 0, 0));
        send_item(coords(1023, 1023, 1023, 1023, 1023, 1023));

        setup(6, sizes(1023, 1023, 1023, 1023, 1023, 1023), orders(0, 1, 2, 3, 4, 5));
        send_item(coords(0, 0, 0, 0, 0, 0));
        send_item(coords(1022, 1022, 1022, 1022, 1022, 1022));
        send_item(coords(1023, 1023, 1023, 1023, 1023, 1023));

        setup(3, sizes(4, 5, 6, 9, 9, 9), orders(2, 0, 1, 7, 7, 7));
        send_item(coords(5, 3, 4, 1023, 1023, 1023));
        send_item(coords(0, 0, 0, 0, 0, 0));
        send_item(coords(6, 0, 0, 0, 0, 0));

        // A repeated axis and an axis beyond the rank both fall back to the identity order.
        setup(3, sizes(4, 5, 6, 9, 9, 9), orders(1, 1, 0, 3, 4, 5));
        send_item(coords(3, 4, 5, 0, 0, 0));
        send_item(coords(1, 2, 3, 0, 0, 0));
        setup(3, sizes(4, 5, 6, 9, 9, 9), orders(0, 1, 5, 3, 4, 5));
        send_item(coords(1, 1, 1, 0, 0, 0));

        setup(4, sizes(3, 0, 7, 2, 1, 1), orders(0, 1, 2, 3, 4, 5));
        send_item(coords(1, 0, 2, 1, 0, 0));
        send_item(coords(0, 5, 0, 0, 0, 0));

        // Only the low bits of the rank count, and zero acts as one.
        wait_drained();
        write_reg(CFG_RANK, 60'hFFF_FFFF_FFFF_FFF8);
        send_item(coords(2, 700, 0, 0, 0, 0));

        setup(7, sizes(2, 3, 4, 5, 6, 7), orders(5, 4, 3, 2, 1, 0));
        send_item(coords(1, 2, 3, 4, 5, 6));
        send_item(coords(1, 1, 1, 1, 1, 1));

        wait_drained();
        write_reg(CFG_SPARE, 60'hABC_DEF0_1234_5678);
        send_item(coords(0, 1, 2, 3, 4, 5));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_setup();
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            n        = $urandom_range(80, 120);
            for (int i = 0; i < n; i++) begin
                send_item(random_coords());
                if ($urandom_range(0, 199) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        $display("Checked %0d offsets from %0d input transfers across %0d view configurations.",
                 sb.returned, sb.accepted, configs);
        $display("%0d of them carried an out-of-range coordinate.", sb.flagged);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
